// File: rtl/utt_pkg.sv
`timescale 1ns / 1ps

package utt_pkg;

  localparam logic [3:0]  StAccept   = 4'd0;
  localparam logic [3:0]  StReject   = 4'd1;
  localparam logic [3:0]  StLast     = 4'd8;
  localparam logic [15:0] ReplUnit   = 16'hFFFD;
  localparam logic [15:0] SurrHiBase = 16'hD7C0;
  localparam logic [15:0] SurrLoBase = 16'hDC00;

  // depth of the record queue between decoder and serializer
  localparam int QDepth = 2;
  localparam int QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_CP   = 2'd1,
    TAIL_REPL = 2'd2,
    TAIL_EOS  = 2'd3
  } tail_e;

  // what one input byte produces: optional replacement, then the tail
  typedef struct packed {
    logic        pre_repl;
    tail_e       tail;
    logic [20:0] cp;
  } rec_t;

  typedef logic [11:0][3:0] row_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  // transition table, one row per state, class 11 in the top nibble
  function automatic logic [3:0] next_state(input logic [3:0] st, input logic [3:0] cls);
    row_t row;
    logic [3:0] ns;
    case (st)
      4'd0:    row = 48'h6411_1785_3210;
      4'd2:    row = 48'h1101_0111_1101;
      4'd3:    row = 48'h1121_2111_1121;
      4'd4:    row = 48'h1111_2111_1111;
      4'd5:    row = 48'h1121_1111_1121;
      4'd6:    row = 48'h1131_3111_1111;
      4'd7:    row = 48'h1131_3111_1131;
      4'd8:    row = 48'h1111_1111_1131;
      default: row = 48'h1111_1111_1111;
    endcase
    if (cls > 4'd11) ns = StReject;
    else             ns = row[cls];
    return ns;
  endfunction

endpackage

// File: rtl/utf8_to_utf16_transcoder_core.sv
`timescale 1ns / 1ps
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+------------------------
// bytes in  | in_byte_i                                    | push_i, full_o
// units out | code_unit_o, last_of_run_o, end_of_string_o  | empty_o, pop_i
//
// one byte is taken per cycle while full_o is low; decoder steps are table lookups
// a record, when a byte gives one, is registered into the queue as the byte is taken; a surrogate pair or a
// replacement plus a second unit holds the output port for two pops
// full_o rises when the two-record queue between decoder and serializer is full
// reset is asynchronous: decoder back to accept and the queue empty

module utf8_to_utf16_transcoder_core import utt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  in_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] code_unit_o,
  output logic        last_of_run_o,
  output logic        end_of_string_o
);

  logic accept;
  logic rec_valid;
  rec_t rec_in;
  rec_t rec_head;
  logic rec_pop;
  logic rec_empty;

  assign accept = push_i && !full_o;

  utt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .rec_valid_o(rec_valid),
    .rec_o      (rec_in)
  );

  utt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (rec_valid),
    .wr_data_i(rec_in),
    .rd_i     (rec_pop),
    .rd_data_o(rec_head),
    .full_o   (full_o),
    .empty_o  (rec_empty)
  );

  utt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_i          (rec_head),
    .rec_empty_i    (rec_empty),
    .rec_pop_o      (rec_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .code_unit_o    (code_unit_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_string_o(end_of_string_o)
  );

endmodule

// File: rtl/utt_front.sv
`timescale 1ns / 1ps

module utt_front import utt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  output logic       rec_valid_o,
  output rec_t       rec_o
);

  logic [3:0]  state_q, state_d;
  logic [20:0] partial_q, partial_d;
  logic [3:0]  cls;
  logic [3:0]  ns1, ns2;
  logic [20:0] pc1, pc2;

  always_comb begin
    cls = byte_class(in_byte_i);
    pc2 = {13'd0, in_byte_i & (8'hFF >> cls)};
    if (state_q != StAccept) begin
      pc1 = {partial_q[14:0], in_byte_i[5:0]};
    end else begin
      pc1 = pc2;
    end
    ns1 = next_state(state_q, cls);
    ns2 = next_state(StAccept, cls);
  end

  always_comb begin
    state_d       = state_q;
    partial_d     = partial_q;
    rec_valid_o   = 1'b0;
    rec_o.pre_repl = 1'b0;
    rec_o.tail    = TAIL_NONE;
    rec_o.cp      = pc1;
    if (accept_i) begin
      if (in_byte_i == 8'd0) begin
        // terminator drops any open sequence
        rec_valid_o = 1'b1;
        rec_o.tail  = TAIL_EOS;
        state_d     = StAccept;
        partial_d   = '0;
      end else if (ns1 == StAccept) begin
        rec_valid_o = 1'b1;
        rec_o.tail  = TAIL_CP;
        state_d     = StAccept;
        partial_d   = pc1;
      end else if (ns1 == StReject) begin
        rec_valid_o = 1'b1;
        if (state_q == StAccept) begin
          rec_o.tail = TAIL_REPL;
          state_d    = StAccept;
          partial_d  = '0;
        end else begin
          // replacement, then the same byte decoded from accept
          rec_o.pre_repl = 1'b1;
          rec_o.cp       = pc2;
          if (ns2 == StAccept) begin
            rec_o.tail = TAIL_CP;
            state_d    = StAccept;
            partial_d  = pc2;
          end else if (ns2 == StReject) begin
            rec_o.tail = TAIL_REPL;
            state_d    = StAccept;
            partial_d  = '0;
          end else begin
            rec_o.tail = TAIL_NONE;
            state_d    = ns2;
            partial_d  = pc2;
          end
        end
      end else begin
        state_d   = ns1;
        partial_d = pc1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StAccept;
      partial_q <= '0;
    end else begin
      state_q   <= state_d;
      partial_q <= partial_d;
    end
  end

endmodule

// File: rtl/utt_queue.sv
`timescale 1ns / 1ps

module utt_queue import utt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  rec_t wr_data_i,
  input  logic rd_i,
  output rec_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam logic [QAw-1:0] PtrLast = QAw'(QDepth - 1);
  localparam logic [QAw:0]   CntFull = (QAw + 1)'(QDepth);

  rec_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAw:0]   cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: rtl/utt_back.sv
`timescale 1ns / 1ps

module utt_back import utt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rec_t        rec_i,
  input  logic        rec_empty_i,
  output logic        rec_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [15:0] code_unit_o,
  output logic        last_of_run_o,
  output logic        end_of_string_o
);

  logic        idx_q, idx_d;
  logic        big;
  logic [15:0] tail_u0, tail_u1;
  logic        tail_two;
  logic [15:0] u0, u1;
  logic        last_idx;
  logic        take;

  always_comb begin
    big      = |rec_i.cp[20:16];
    tail_two = 1'b0;
    tail_u1  = SurrLoBase + {6'd0, rec_i.cp[9:0]};
    case (rec_i.tail)
      TAIL_CP: begin
        if (big) begin
          tail_u0  = SurrHiBase + {5'd0, rec_i.cp[20:10]};
          tail_two = 1'b1;
        end else begin
          tail_u0 = rec_i.cp[15:0];
        end
      end
      TAIL_REPL: tail_u0 = ReplUnit;
      default:   tail_u0 = 16'd0;
    endcase

    if (rec_i.pre_repl) begin
      u0       = ReplUnit;
      u1       = tail_u0;
      last_idx = (rec_i.tail != TAIL_NONE);
    end else begin
      u0       = tail_u0;
      u1       = tail_u1;
      last_idx = tail_two;
    end
  end

  assign empty_o         = rec_empty_i;
  assign code_unit_o     = idx_q ? u1 : u0;
  assign last_of_run_o   = (idx_q == last_idx);
  assign end_of_string_o = (rec_i.tail == TAIL_EOS);

  assign take      = pop_i && !rec_empty_i;
  assign rec_pop_o = take && last_of_run_o;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_of_run_o ? 1'b0 : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// File: rtl/utt_checker.sv
`timescale 1ns / 1ps

module utt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty_o,
  input logic        pop_i,
  input logic [15:0] code_unit_o,
  input logic        last_of_run_o,
  input logic        end_of_string_o
);

  // terminator is always a lone zero unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && end_of_string_o) |-> (code_unit_o == 16'd0 && last_of_run_o))
    else $error("terminator unit malformed");

  // a unit that is not last is a replacement or a high surrogate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !last_of_run_o) |->
      (code_unit_o == 16'hFFFD || (code_unit_o >= 16'hD800 && code_unit_o <= 16'hDBFF)))
    else $error("unexpected unit before end of run");

  // the second unit of a run follows right away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !last_of_run_o) |=> !empty_o)
    else $error("run broken after first unit");

  // a waiting unit holds while not popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(code_unit_o) && $stable(last_of_run_o)))
    else $error("waiting unit changed");

endmodule

bind utf8_to_utf16_transcoder_core utt_checker u_utt_checker (.*);
